// File: rtl/core/wheel_speed_to_servo_angle_defines.svh
// Assertion macros shared by the RTL.
`ifndef WHEEL_SPEED_TO_SERVO_ANGLE_DEFINES_SVH
`define WHEEL_SPEED_TO_SERVO_ANGLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WSA_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define WSA_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define WSA_ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define WSA_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/core/wsa_pkg.sv
package wsa_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int SPEED_FRAC  = 8;
    localparam int COEF_FRAC   = 40;

    localparam int ACC_W       = 64;
    localparam int ANGLE_W     = 8;
    localparam int NUM_COEF    = 7;
    localparam int TABLE_FRAC  = 48;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

    // curve-fit coefficients c0..c6, signed Q.48
    localparam logic signed [ACC_W-1:0] POLY_Q48 [NUM_COEF] = '{
        64'sd25697735737142316,
        64'sd381442194475384,
        -64'sd7247491774072,
        -64'sd1060928713140,
        64'sd108341328617,
        64'sd12814698812,
        -64'sd190340723
    };

    // coefficient rescaled to Q.frac, magnitude rounded half away from zero
    function automatic logic signed [ACC_W-1:0] coef_at(input int idx, input int frac);
        logic signed [ACC_W-1:0] c;
        logic [ACC_W-1:0] m;
        int sh;
        c  = POLY_Q48[idx];
        sh = TABLE_FRAC - frac;
        m  = c[ACC_W-1] ? ACC_W'(-c) : ACC_W'(c);
        if (sh > 0) begin
            m = (m + (64'd1 << (sh - 1))) >> sh;
        end
        return c[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: rtl/core/wsa_cell.sv
// One Horner step: acc = sat(floor(acc * s / 2^F)) then acc = sat(acc + COEF).
// Three register stages: low partial product, full product, shift/saturate/add.
module wsa_cell #(
    parameter int SPEED_WIDTH = wsa_pkg::SPEED_WIDTH,
    parameter int SPEED_FRAC  = wsa_pkg::SPEED_FRAC,
    parameter logic signed [wsa_pkg::ACC_W-1:0] COEF = '0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           valid_in,
    input  logic signed [wsa_pkg::ACC_W-1:0] acc_in,
    input  logic signed [SPEED_WIDTH:0]    spd_in,
    output logic                           valid_out,
    output logic signed [wsa_pkg::ACC_W-1:0] acc_out,
    output logic signed [SPEED_WIDTH:0]    spd_out
);

    localparam int AW   = wsa_pkg::ACC_W;
    localparam int HW   = AW / 2;
    localparam int SW1  = SPEED_WIDTH + 1;
    localparam int PW   = AW + SW1;
    localparam int LOW  = HW + 1 + SW1;

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [SW1-1:0]   s1_reg, s2_reg, s3_reg;
    logic signed [HW-1:0]    hi1_reg;
    logic signed [LOW-1:0]   plo1_reg;
    logic signed [PW-1:0]    prod2_reg;
    logic signed [AW-1:0]    acc3_reg;

    logic signed [LOW-1:0]   plo_next;
    logic signed [PW-1:0]    phi;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    shr;
    logic [PW-AW:0]          upper;
    logic signed [AW-1:0]    q;
    logic signed [AW:0]      sum;
    logic signed [AW-1:0]    acc_next;

    // stage 1: unsigned low half times speed
    assign plo_next = $signed({1'b0, acc_in[HW-1:0]}) * spd_in;

    // stage 2: signed high half times speed, merged with the low partial
    assign phi       = PW'(hi1_reg * s1_reg);
    assign prod_next = (phi <<< HW) + PW'(plo1_reg);

    // stage 3: floor shift, clamp to 64 bits, saturating coefficient add
    assign shr   = prod2_reg >>> SPEED_FRAC;
    assign upper = shr[PW-1:AW-1];
    always_comb begin
        if ((&upper) || !(|upper)) begin
            q = shr[AW-1:0];
        end else if (shr[PW-1]) begin
            q = {1'b1, {(AW-1){1'b0}}};
        end else begin
            q = {1'b0, {(AW-1){1'b1}}};
        end
        sum = {q[AW-1], q} + {COEF[AW-1], COEF};
        if (sum[AW] != sum[AW-1]) begin
            acc_next = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            acc_next = sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo1_reg  <= plo_next;
            hi1_reg   <= acc_in[AW-1:HW];
            s1_reg    <= spd_in;
            prod2_reg <= prod_next;
            s2_reg    <= s1_reg;
            acc3_reg  <= acc_next;
            s3_reg    <= s2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign acc_out   = acc3_reg;
    assign spd_out   = s3_reg;

endmodule

// File: rtl/core/wheel_speed_to_servo_angle.sv
// channel   | ports           | contents
// ----------+-----------------+---------------------------------------------
// s_ (in)   | tvalid/tready   | tdata: speed (signed, SPEED_WIDTH bits)
// m_ (out)  | tvalid/tready   | tdata: angle [7:0]; tuser: clamped
// config    | wheel_side_we   | wheel_side_wdata: 0 left, 1 right
//
// One request per cycle. Pipeline: one input stage (side negate),
// six Horner cells of three stages each (split 64x17 multiply), one output stage.
// The whole pipe advances together; it stalls only while the output holds a
// result that is not taken. Synchronous active-low reset clears valids and side.
`include "wheel_speed_to_servo_angle_defines.svh"

module wheel_speed_to_servo_angle #(
    parameter int SPEED_WIDTH = wsa_pkg::SPEED_WIDTH,
    parameter int SPEED_FRAC  = wsa_pkg::SPEED_FRAC,
    parameter int COEF_FRAC   = wsa_pkg::COEF_FRAC
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wheel_side_we,
    input  logic                                  wheel_side_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SPEED_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // speed
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wsa_pkg::ANGLE_W-1:0]           m_tdata,  // angle
    output logic                                  m_tuser   // clamped
);

    localparam int AW    = wsa_pkg::ACC_W;
    localparam int SW1   = SPEED_WIDTH + 1;
    localparam int NCELL = wsa_pkg::NUM_COEF - 1;
    localparam int ANW   = wsa_pkg::ANGLE_W;

    logic                  en;
    logic                  side_reg;
    logic                  v0_reg;
    logic signed [SW1-1:0] s0_reg;
    logic signed [SW1-1:0] sx;
    logic                  m_valid_reg;
    logic [ANW-1:0]        angle_reg;
    logic                  clamped_reg;

    logic                  valid_c [NCELL+1];
    logic signed [AW-1:0]  acc_c   [NCELL+1];
    logic signed [SW1-1:0] spd_c   [NCELL];

    logic                  acc_neg;
    logic [AW-1:0]         mag;
    logic [AW-1:0]         whole;
    logic [ANW-1:0]        angle_next;
    logic                  clamped_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 1'b0;
        end else if (wheel_side_we) begin
            side_reg <= wheel_side_wdata;
        end
    end

    assign sx = {s_tdata[SPEED_WIDTH-1], s_tdata[SPEED_WIDTH-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= side_reg ? -sx : sx;
        end
    end

    assign valid_c[0] = v0_reg;
    assign acc_c[0]   = wsa_pkg::coef_at(NCELL, COEF_FRAC);
    assign spd_c[0]   = s0_reg;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k < NCELL - 1) begin : g_mid
            wsa_cell #(
                .SPEED_WIDTH (SPEED_WIDTH),
                .SPEED_FRAC  (SPEED_FRAC),
                .COEF        (wsa_pkg::coef_at(NCELL - 1 - k, COEF_FRAC))
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .valid_in  (valid_c[k]),
                .acc_in    (acc_c[k]),
                .spd_in    (spd_c[k]),
                .valid_out (valid_c[k+1]),
                .acc_out   (acc_c[k+1]),
                .spd_out   (spd_c[k+1])
            );
        end else begin : g_last
            wsa_cell #(
                .SPEED_WIDTH (SPEED_WIDTH),
                .SPEED_FRAC  (SPEED_FRAC),
                .COEF        (wsa_pkg::coef_at(NCELL - 1 - k, COEF_FRAC))
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .valid_in  (valid_c[k]),
                .acc_in    (acc_c[k]),
                .spd_in    (spd_c[k]),
                .valid_out (valid_c[k+1]),
                .acc_out   (acc_c[k+1]),
                .spd_out   ()
            );
        end
    end

    // truncate toward zero, then clamp to 0..180
    assign acc_neg = acc_c[NCELL][AW-1];
    assign mag     = acc_neg ? AW'(-acc_c[NCELL]) : AW'(acc_c[NCELL]);
    assign whole   = mag >> COEF_FRAC;

    always_comb begin
        if (acc_neg && (whole != '0)) begin
            angle_next   = '0;
            clamped_next = 1'b1;
        end else if (!acc_neg && (whole > AW'(wsa_pkg::MAX_ANGLE))) begin
            angle_next   = wsa_pkg::MAX_ANGLE;
            clamped_next = 1'b1;
        end else begin
            angle_next   = whole[ANW-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_c[NCELL];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg   <= angle_next;
            clamped_reg <= clamped_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = angle_reg;
    assign m_tuser  = clamped_reg;

    `WSA_ASSERT_IMPLY(a_angle_range, aclk, aresetn, m_valid_reg, angle_reg <= wsa_pkg::MAX_ANGLE, "angle above limit")
    `WSA_ASSERT_IMPLY(a_clamp_edge, aclk, aresetn, m_valid_reg && clamped_reg, angle_reg == '0 || angle_reg == wsa_pkg::MAX_ANGLE, "clamped angle not at a limit")
    `WSA_ASSERT_IMPLY(a_stall_blocks, aclk, aresetn, m_valid_reg && !m_tready, !s_tready && !en, "pipe moved while output stalled")

endmodule
